>>> src/lcdw_pkg.sv
package lcdw_pkg;

  // Width of the request value field and default digit limit.
  localparam int VALUE_W        = 16;
  localparam int MAX_DIGITS_DEF = 5;
  localparam int INIT_CMDS      = 4;

  // Request codes.
  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_CHAR     = 2'd1,
    OP_UNSIGNED = 2'd2,
    OP_SIGNED   = 2'd3
  } op_t;

  // Kind of bus write that the controller asks the datapath to form.
  typedef enum logic [2:0] {
    WK_INIT,
    WK_ADDR,
    WK_CHAR,
    WK_MINUS,
    WK_DIGIT
  } wr_kind_t;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW1_OFFSET  = 8'h40;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;

  // Fixed setup sequence: function set, display on, entry mode, clear.
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h38;
      3'd1:    c = 8'h0C;
      3'd2:    c = 8'h06;
      default: c = 8'h01;
    endcase
    return c;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_req;
    logic     conv_step;
    logic     load_out;
    wr_kind_t kind;
    logic [2:0] idx;
    logic     last;
  } lcdw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t        opcode;
    logic       negative;
    logic [2:0] digits;
  } lcdw_sts_t;

endpackage

>>> src/lcdw_req_if.sv
interface lcdw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  line;
  logic [5:0]  column;
  logic [15:0] value;
  logic [2:0]  digit_count;

  modport source (output valid, opcode, line, column, value, digit_count, input ready);
  modport sink   (input valid, opcode, line, column, value, digit_count, output ready);
endinterface

>>> src/lcdw_wr_if.sv
interface lcdw_wr_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, is_data, bus_byte, last, input ready);
  modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

>>> src/lcdw_datapath.sv
module lcdw_datapath #(
  parameter int MAX_DIGITS = lcdw_pkg::MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic [1:0]           opcode,
  input  logic [1:0]           line,
  input  logic [5:0]           column,
  input  logic [15:0]          value,
  input  logic [2:0]           digit_count,
  input  lcdw_pkg::lcdw_cmd_t  cmd,
  output lcdw_pkg::lcdw_sts_t  sts,
  output logic                 is_data,
  output logic [7:0]           bus_byte,
  output logic                 last
);

  localparam int VW = lcdw_pkg::VALUE_W;

  logic [7:0]    addr_base;
  logic [7:0]    char_byte;
  logic [VW-1:0] shifter;
  logic [3:0]    bcd [MAX_DIGITS];

  logic          neg_in;
  logic [VW-1:0] mag_in;
  logic [2:0]    digits_in;
  logic [3:0]    adj [MAX_DIGITS];
  logic [3:0]    digit_sel;
  logic [7:0]    byte_next;

  always_comb begin
    neg_in    = (lcdw_pkg::op_t'(opcode) == lcdw_pkg::OP_SIGNED) && value[VW-1];
    mag_in    = neg_in ? VW'(~value + 16'd1) : value;
    digits_in = (digit_count > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : digit_count;
  end

  // Add-3 correction of each BCD digit before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? 4'(bcd[i] + 4'd3) : bcd[i];
    end
  end

  always_comb begin
    digit_sel = 4'd0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (cmd.idx == 3'(i)) begin
        digit_sel = bcd[i];
      end
    end
  end

  always_comb begin
    unique case (cmd.kind)
      lcdw_pkg::WK_INIT:  byte_next = lcdw_pkg::init_cmd(cmd.idx);
      lcdw_pkg::WK_ADDR:  byte_next = lcdw_pkg::CMD_SET_ADDR | addr_base;
      lcdw_pkg::WK_CHAR:  byte_next = char_byte;
      lcdw_pkg::WK_MINUS: byte_next = lcdw_pkg::ASCII_MINUS;
      default:            byte_next = lcdw_pkg::ASCII_ZERO | {4'd0, digit_sel};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      sts.opcode   <= lcdw_pkg::op_t'(opcode);
      sts.negative <= neg_in;
      sts.digits   <= digits_in;
      addr_base    <= 8'({2'b00, column} + 8'hFF
                         + ((line == 2'd1) ? 8'h00 : lcdw_pkg::ROW1_OFFSET));
      char_byte    <= value[7:0];
      shifter      <= mag_in;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
    end else if (cmd.conv_step) begin
      // Double dabble: one magnitude bit enters the BCD digits per step.
      shifter <= {shifter[VW-2:0], 1'b0};
      bcd[0]  <= {adj[0][2:0], shifter[VW-1]};
      for (int i = 1; i < MAX_DIGITS; i++) begin
        bcd[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
    if (cmd.load_out) begin
      is_data  <= (cmd.kind != lcdw_pkg::WK_INIT) && (cmd.kind != lcdw_pkg::WK_ADDR);
      bus_byte <= byte_next;
      last     <= cmd.last;
    end
  end

endmodule

>>> src/lcdw_controller.sv
module lcdw_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lcdw_pkg::lcdw_sts_t sts,
  output lcdw_pkg::lcdw_cmd_t cmd
);

  localparam int CW = $clog2(lcdw_pkg::VALUE_W);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_CONV, S_PICK, S_SEND} state_t;
  typedef enum logic [2:0] {PH_INIT, PH_ADDR, PH_CHAR, PH_MINUS, PH_DIGIT} phase_t;

  state_t      state;
  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [CW-1:0] cnt;
  logic        last_sent;
  logic        pick_last;
  lcdw_pkg::wr_kind_t kind;

  assign in_ready = (state == S_IDLE);

  // Chooses the write to form now and what follows it.
  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    pick_last  = 1'b0;
    kind       = lcdw_pkg::WK_DIGIT;
    unique case (phase)
      PH_INIT: begin
        kind      = lcdw_pkg::WK_INIT;
        pick_last = (idx == 3'(lcdw_pkg::INIT_CMDS - 1));
        idx_next  = 3'(idx + 3'd1);
      end
      PH_ADDR: begin
        kind = lcdw_pkg::WK_ADDR;
        if (sts.opcode == lcdw_pkg::OP_CHAR) begin
          phase_next = PH_CHAR;
        end else if (sts.negative) begin
          phase_next = PH_MINUS;
        end else if (sts.digits == 3'd0) begin
          pick_last = 1'b1;
        end else begin
          phase_next = PH_DIGIT;
          idx_next   = 3'(sts.digits - 3'd1);
        end
      end
      PH_CHAR: begin
        kind      = lcdw_pkg::WK_CHAR;
        pick_last = 1'b1;
      end
      PH_MINUS: begin
        kind = lcdw_pkg::WK_MINUS;
        if (sts.digits == 3'd0) begin
          pick_last = 1'b1;
        end else begin
          phase_next = PH_DIGIT;
          idx_next   = 3'(sts.digits - 3'd1);
        end
      end
      default: begin
        kind      = lcdw_pkg::WK_DIGIT;
        pick_last = (idx == 3'd0);
        idx_next  = 3'(idx - 3'd1);
      end
    endcase
  end

  always_comb begin
    cmd.load_req  = in_valid && (state == S_IDLE);
    cmd.conv_step = (state == S_CONV);
    cmd.load_out  = (state == S_PICK);
    cmd.kind      = kind;
    cmd.idx       = idx;
    cmd.last      = pick_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_INIT;
      idx       <= 3'd0;
      cnt       <= '0;
      last_sent <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt <= '0;
          idx <= 3'd0;
          if (sts.opcode == lcdw_pkg::OP_INIT) begin
            phase <= PH_INIT;
            state <= S_PICK;
          end else if (sts.opcode == lcdw_pkg::OP_CHAR) begin
            phase <= PH_ADDR;
            state <= S_PICK;
          end else begin
            phase <= PH_ADDR;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= CW'(cnt + 1'b1);
          if (cnt == CW'(lcdw_pkg::VALUE_W - 1)) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          phase     <= phase_next;
          idx       <= idx_next;
          last_sent <= pick_last;
          out_valid <= 1'b1;
          state     <= S_SEND;
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= last_sent ? S_IDLE : S_PICK;
          end
        end
      endcase
    end
  end

endmodule

>>> src/char_lcd_number_writer.sv
// Channel | Role   | Payload
// req     | sink   | opcode, line, column, value, digit_count
// wr      | source | is_data, bus_byte, last
//
// One request is taken at a time, and only from the idle state. After acceptance
// a decode state follows; number requests then pass through the shift-and-add-3
// BCD converter. Each bus write passes through a pick state and a send state, and
// the send state holds for as long as wr.ready stays low. After the last beat the
// controller returns to the idle state before the next request can be taken.
// Reset is synchronous and clears only the controller; a stalled beat holds its
// payload in the output register.
module char_lcd_number_writer #(
  parameter int MAX_DIGITS = lcdw_pkg::MAX_DIGITS_DEF
) (
  input logic        clk,
  input logic        rst,
  lcdw_req_if.sink   req,
  lcdw_wr_if.source  wr
);

  lcdw_pkg::lcdw_cmd_t cmd;
  lcdw_pkg::lcdw_sts_t sts;

  // The controller sequences the writes of a request and owns both handshakes.
  lcdw_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (wr.valid),
    .out_ready (wr.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the request, converts the magnitude to BCD and forms
  // each bus byte into the output register.
  lcdw_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .opcode      (req.opcode),
    .line        (req.line),
    .column      (req.column),
    .value       (req.value),
    .digit_count (req.digit_count),
    .cmd         (cmd),
    .sts         (sts),
    .is_data     (wr.is_data),
    .bus_byte    (wr.bus_byte),
    .last        (wr.last)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Clock and run-length constants.
  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_REQS      = 480;
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS       = 6_000_000;

  // The block is built with its default digit limit.
  localparam int DIGIT_LIMIT = lcdw_pkg::MAX_DIGITS_DEF;

  // The display setup sequence, first command in the top byte: function set,
  // display on, entry mode, clear.
  localparam logic [31:0] SETUP_CMDS = {8'h38, 8'h0C, 8'h06, 8'h01};

  // One display request together with the sender's pacing for it. The gap is
  // the number of idle cycles the sender inserts before offering it, and
  // wait_drain holds it back until every bus write owed so far has arrived.
  typedef struct packed {
    lcdw_pkg::op_t opcode;
    logic [1:0]    line;
    logic [5:0]    column;
    logic [15:0]   value;
    logic [2:0]    digit_count;
    logic [1:0]    gap;
    logic          wait_drain;
  } lcd_request_t;

  // One bus write as it leaves the block.
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } bus_write_t;

  logic clk = 1'b0;
  logic rst;

  lcdw_req_if req_ch ();
  lcdw_wr_if  wr_ch ();

  char_lcd_number_writer i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .wr  (wr_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Requests waiting to be offered, the request currently on the channel,
  // and the bus writes that accepted requests still owe, oldest first.
  lcd_request_t pending[$];
  lcd_request_t in_flight;
  bus_write_t   writes_due[$];

  int unsigned req_idle    = 0;
  int unsigned wr_stall    = 0;
  int unsigned beats_seen  = 0;
  int unsigned error_count = 0;

  // Works out the full run of bus writes that one request produces and
  // appends it to the writes still owed. An init request is the fixed setup
  // sequence. Every other request starts with a set-address command; the
  // address is column-1 on the first row and column-1+0x40 on the second,
  // wrapping within eight bits, so column zero lands on 0xFF or 0x3F. A char
  // request then sends the low byte of its value. A number request sends an
  // optional minus sign and then the low-order digits of the magnitude, most
  // significant first; the digit count saturates at the limit, and digits
  // that do not fit are simply lost.
  function automatic void queue_writes(lcd_request_t r);
    bus_write_t  run[$];
    logic [7:0]  addr;
    int unsigned mag;
    int unsigned scale;
    int          n_digits;
    if (r.opcode == lcdw_pkg::OP_INIT) begin
      for (int i = 0; i < 4; i++) begin
        run.push_back(bus_write_t'{1'b0, SETUP_CMDS[31 - 8 * i -: 8], 1'b0});
      end
    end else begin
      addr = r.column - 8'd1 + ((r.line == 2'd1) ? 8'h00 : lcdw_pkg::ROW1_OFFSET);
      run.push_back(bus_write_t'{1'b0, lcdw_pkg::CMD_SET_ADDR | addr, 1'b0});
      if (r.opcode == lcdw_pkg::OP_CHAR) begin
        run.push_back(bus_write_t'{1'b1, r.value[7:0], 1'b0});
      end else begin
        mag = r.value;
        // The most negative value comes out as 32768, since the magnitude
        // is taken with one bit more than the value has.
        if (r.opcode == lcdw_pkg::OP_SIGNED && r.value[15]) begin
          mag = 32'h10000 - r.value;
          run.push_back(bus_write_t'{1'b1, lcdw_pkg::ASCII_MINUS, 1'b0});
        end
        n_digits = (r.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : r.digit_count;
        scale = 1;
        for (int i = 1; i < n_digits; i++) begin
          scale *= 10;
        end
        for (int i = 0; i < n_digits; i++) begin
          run.push_back(bus_write_t'{1'b1,
                                     lcdw_pkg::ASCII_ZERO | 8'((mag / scale) % 10),
                                     1'b0});
          scale /= 10;
        end
      end
    end
    // With zero digits the address command (or the minus sign) ends the run.
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) begin
      writes_due.push_back(run[i]);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch on beat %0d: expected 0x%0h, actual 0x%0h",
               $time, name, beats_seen, want, got);
    end
  endfunction

  task automatic add_request(lcdw_pkg::op_t op, logic [1:0] ln, logic [5:0] col,
                             logic [15:0] val, logic [2:0] dc);
    lcd_request_t r;
    r.opcode      = op;
    r.line        = ln;
    r.column      = col;
    r.value       = val;
    r.digit_count = dc;
    r.gap         = 2'($urandom_range(0, 3));
    r.wait_drain  = 1'b0;
    pending.push_back(r);
  endtask

  // Request driver. The valid level for the next cycle is settled in a local
  // variable first, so that valid gets a single nonblocking update per edge
  // and stays high across back-to-back beats. The expected writes of a
  // request are queued at the edge where it is accepted.
  always @(posedge clk) begin
    logic offering;
    if (rst) begin
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= lcdw_pkg::OP_INIT;
      req_ch.line        <= '0;
      req_ch.column      <= '0;
      req_ch.value       <= '0;
      req_ch.digit_count <= '0;
    end else begin
      offering = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        queue_writes(in_flight);
        offering = 1'b0;
        req_idle = (pending.size() > 0) ? pending[0].gap : 0;
      end
      if (!offering) begin
        if (req_idle > 0) begin
          req_idle--;
        end else if (pending.size() > 0 &&
                     !(pending[0].wait_drain && writes_due.size() > 0)) begin
          in_flight = pending.pop_front();
          req_ch.opcode      <= in_flight.opcode;
          req_ch.line        <= in_flight.line;
          req_ch.column      <= in_flight.column;
          req_ch.value       <= in_flight.value;
          req_ch.digit_count <= in_flight.digit_count;
          offering = 1'b1;
        end
      end
      req_ch.valid <= offering;
    end
  end

  // Bus write monitor. Every accepted beat is checked against the oldest
  // owed write. After each beat the receiver draws a random stall of ready,
  // except in stretches where it keeps ready high throughout, and twice it
  // holds off for a long stretch so that the block backs up and stops taking
  // requests while the driver keeps offering.
  always @(posedge clk) begin
    bus_write_t want;
    if (rst) begin
      wr_ch.ready <= 1'b0;
    end else begin
      if (wr_ch.valid && wr_ch.ready) begin
        if (writes_due.size() == 0) begin
          error_count++;
          $display("%0t: beat %0d with nothing expected: is_data %0b bus_byte 0x%0h last %0b",
                   $time, beats_seen, wr_ch.is_data, wr_ch.bus_byte, wr_ch.last);
        end else begin
          want = writes_due.pop_front();
          check_field("is_data", want.is_data, wr_ch.is_data);
          check_field("bus_byte", want.bus_byte, wr_ch.bus_byte);
          check_field("last", want.last, wr_ch.last);
        end
        beats_seen++;
        if (beats_seen == 60 || beats_seen == 1200) begin
          wr_stall = LONG_HOLD_CYCLES;
        end else if ((beats_seen / 150) % 4 == 3) begin
          wr_stall = 0;
        end else begin
          wr_stall = $urandom_range(0, 3);
        end
      end
      if (wr_stall > 0) begin
        wr_stall--;
        wr_ch.ready <= 1'b0;
      end else begin
        wr_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    lcd_request_t r;

    rst = 1'b1;

    // Directed requests. Init ignores its other fields, so it is sent once
    // with all of them set and once with all of them clear.
    add_request(lcdw_pkg::OP_INIT, 2'd3, 6'd63, 16'hFFFF, 3'd7);
    add_request(lcdw_pkg::OP_INIT, 2'd0, 6'd0, 16'h0000, 3'd0);
    // Char requests over both rows, the column extremes, column zero and
    // line codes outside 1 and 2; only the low byte of the value goes out.
    add_request(lcdw_pkg::OP_CHAR, 2'd1, 6'd1, 16'h0041, 3'd0);
    add_request(lcdw_pkg::OP_CHAR, 2'd2, 6'd40, 16'hFF00, 3'd5);
    add_request(lcdw_pkg::OP_CHAR, 2'd0, 6'd0, 16'h00FF, 3'd7);
    add_request(lcdw_pkg::OP_CHAR, 2'd3, 6'd63, 16'h1234, 3'd1);
    add_request(lcdw_pkg::OP_CHAR, 2'd1, 6'd0, 16'h807E, 3'd2);
    // Unsigned numbers: zero, the largest value, a saturated digit count,
    // a count that drops the leading digits, and no digits at all.
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd1, 6'd1, 16'd0, 3'd5);
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd2, 6'd40, 16'd65535, 3'd5);
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd1, 6'd10, 16'd65535, 3'd7);
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd2, 6'd3, 16'd12345, 3'd6);
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd1, 6'd5, 16'd12345, 3'd2);
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd2, 6'd7, 16'd9, 3'd0);
    add_request(lcdw_pkg::OP_UNSIGNED, 2'd2, 6'd42, 16'hAAAA, 3'd4);
    // Signed numbers: the most negative value, minus one, the largest
    // positive value, negative and non-negative with no digits.
    add_request(lcdw_pkg::OP_SIGNED, 2'd1, 6'd1, 16'h8000, 3'd5);
    add_request(lcdw_pkg::OP_SIGNED, 2'd2, 6'd40, 16'hFFFF, 3'd5);
    add_request(lcdw_pkg::OP_SIGNED, 2'd1, 6'd16, 16'h7FFF, 3'd5);
    add_request(lcdw_pkg::OP_SIGNED, 2'd2, 6'd1, 16'hFFFF, 3'd0);
    add_request(lcdw_pkg::OP_SIGNED, 2'd1, 6'd2, 16'h0000, 3'd0);
    add_request(lcdw_pkg::OP_SIGNED, 2'd0, 6'd0, 16'h8001, 3'd7);
    add_request(lcdw_pkg::OP_SIGNED, 2'd2, 6'd20, 16'hD8F1, 3'd3);
    add_request(lcdw_pkg::OP_SIGNED, 2'd1, 6'd21, 16'h5555, 3'd1);

    // Random requests. Most stay within the documented ranges; about one in
    // ten pushes the line, column or digit count outside them. Values mix
    // full-range words with small numbers, small negatives and words near
    // the most negative value. Some stretches run with no sender gaps, and
    // now and then a request waits until the block has fully drained.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r.opcode = lcdw_pkg::op_t'($urandom_range(0, 3));
      r.line   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                             : 2'($urandom_range(1, 2));
      r.column = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                             : 6'($urandom_range(1, 40));
      case ($urandom_range(0, 3))
        0:       r.value = 16'($urandom);
        1:       r.value = 16'($urandom_range(0, 99));
        2:       r.value = 16'hFFFF - 16'($urandom_range(0, 99));
        default: r.value = 16'h8000 | 16'($urandom_range(0, 15));
      endcase
      r.digit_count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 5));
      r.gap        = ((n / 60) % 4 == 1) ? 2'd0 : 2'($urandom_range(0, 3));
      r.wait_drain = (n % 120 == 100);
      pending.push_back(r);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request is in and every owed write has come out, then
    // give the block time to show any stray beat.
    while (pending.size() > 0 || req_ch.valid || writes_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
